// ===== hw/rtl/dpb_pkg.sv =====
// ----------------------------------------------------------------------------
// dpb_pkg
// shared types, register indexes, reset values and helpers for the depth
// pixel back-projection block
// ----------------------------------------------------------------------------
`default_nettype none

package dpb_pkg;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SAMPLE_STEP    = 3'd0,
        REG_MIN_DEPTH      = 3'd1,
        REG_MAX_DEPTH      = 3'd2,
        REG_CONFIDENCE_MIN = 3'd3,
        REG_INTRINSICS     = 3'd4,
        REG_ROW_X          = 3'd5,
        REG_ROW_Y          = 3'd6,
        REG_ROW_Z          = 3'd7
    } cfg_index_t;

    // reset values
    localparam logic [7:0]  SAMPLE_STEP_RESET = 8'd1;
    localparam logic [15:0] MIN_DEPTH_RESET   = 16'd0;
    localparam logic [15:0] MAX_DEPTH_RESET   = 16'hFFFF;
    localparam logic [7:0]  CONF_MIN_RESET    = 8'd0;
    localparam logic [63:0] INTRINSICS_RESET  = 64'h0;
    localparam logic [63:0] ROW_X_RESET       = 64'h4000_0000_0000_0000;
    localparam logic [63:0] ROW_Y_RESET       = 64'h0000_4000_0000_0000;
    localparam logic [63:0] ROW_Z_RESET       = 64'h0000_0000_4000_0000;

    // world coordinate limits
    localparam logic signed [31:0] WORLD_MAX = 32'sd1048575;
    localparam logic signed [31:0] WORLD_MIN = -32'sd1048576;

    // colour and label travelling beside the arithmetic
    typedef struct packed {
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
        logic [31:0] label;
    } side_t;

    // four steps of restoring remainder, one dividend bit per step
    function automatic logic [7:0] rem_step4(
        input logic [7:0] rem,
        input logic [3:0] bits,
        input logic [7:0] divisor
    );
        logic [8:0] r;
        r = {1'b0, rem};
        for (int i = 3; i >= 0; i--)
        begin
            r = {r[7:0], bits[i]};
            if (r >= {1'b0, divisor})
            begin
                r = r - {1'b0, divisor};
            end
        end
        return r[7:0];
    endfunction

    // clamp to the 21-bit signed output range
    function automatic logic signed [20:0] sat21(input logic signed [31:0] w);
        logic signed [20:0] res;
        if (w > WORLD_MAX)
        begin
            res = 21'sh0FFFFF;
        end
        else if (w < WORLD_MIN)
        begin
            res = 21'sh100000;
        end
        else
        begin
            res = w[20:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dpb_pixel_if.sv =====
// ----------------------------------------------------------------------------
// dpb_pixel_if
// depth pixel channel: valid/ready handshake with pixel payload
// ----------------------------------------------------------------------------
`default_nettype none

interface dpb_pixel_if;
    logic               valid;
    logic               ready;
    logic [11:0]        column;
    logic [11:0]        row_index;
    logic [15:0]        depth_mm;
    logic [7:0]         confidence;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic signed [31:0] label_in;
    logic               label_present;

    modport source (
        output valid, column, row_index, depth_mm, confidence, blue, green, red,
               label_in, label_present,
        input  ready
    );

    modport sink (
        input  valid, column, row_index, depth_mm, confidence, blue, green, red,
               label_in, label_present,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/dpb_point_if.sv =====
// ----------------------------------------------------------------------------
// dpb_point_if
// world point channel: valid/ready handshake with point payload
// ----------------------------------------------------------------------------
`default_nettype none

interface dpb_point_if;
    logic               valid;
    logic               ready;
    logic signed [20:0] world_x;
    logic signed [20:0] world_y;
    logic signed [20:0] world_z;
    logic [7:0]         out_blue;
    logic [7:0]         out_green;
    logic [7:0]         out_red;
    logic [31:0]        label_out;

    modport source (
        output valid, world_x, world_y, world_z, out_blue, out_green, out_red,
               label_out,
        input  ready
    );

    modport sink (
        input  valid, world_x, world_y, world_z, out_blue, out_green, out_red,
               label_out,
        output ready
    );
endinterface

`default_nettype wire

// ===== hw/rtl/depth_pixel_backprojection.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// pinhole back-projection of gated depth pixels to world millimetres
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake       payload
//  pixel     in         valid/ready     column, row, depth, confidence, colour, label
//  point     out        valid/ready     world x/y/z, colour, label
//  wr_*      in         enable only     register index and 64-bit data
//
//  one pixel per clock sustained while point is ready; a kept pixel is
//  carried from its transfer through stages one to six and the output
//  register, from which it appears on point
//  rejected pixels travel the pipe and are dropped at the output register
//  each stage holds while its successor is full and stalled, so bubbles close
//  up and a pixel is still taken while a finished point waits and a stage is empty
//  reset clears the valid bits and loads the configuration reset values
//
`default_nettype none

module depth_pixel_backprojection
    import dpb_pkg::*;
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    dpb_pixel_if.sink        pixel,
    dpb_point_if.source      point,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [63:0] wr_data
);

    // used bits of the principal point fields
    localparam int CBITS = (COORD_BITS + 4 > 16) ? 16 : COORD_BITS + 4;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  step_reg;
    logic [15:0] min_depth_reg;
    logic [15:0] max_depth_reg;
    logic [7:0]  conf_min_reg;
    logic [63:0] intr_reg;
    logic [63:0] row_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= SAMPLE_STEP_RESET;
            min_depth_reg <= MIN_DEPTH_RESET;
            max_depth_reg <= MAX_DEPTH_RESET;
            conf_min_reg  <= CONF_MIN_RESET;
            intr_reg      <= INTRINSICS_RESET;
            row_reg[0]    <= ROW_X_RESET;
            row_reg[1]    <= ROW_Y_RESET;
            row_reg[2]    <= ROW_Z_RESET;
        end
        else if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                REG_SAMPLE_STEP:    step_reg      <= wr_data[7:0];
                REG_MIN_DEPTH:      min_depth_reg <= wr_data[15:0];
                REG_MAX_DEPTH:      max_depth_reg <= wr_data[15:0];
                REG_CONFIDENCE_MIN: conf_min_reg  <= wr_data[7:0];
                REG_INTRINSICS:     intr_reg      <= wr_data;
                REG_ROW_X:          row_reg[0]    <= wr_data;
                REG_ROW_Y:          row_reg[1]    <= wr_data;
                REG_ROW_Z:          row_reg[2]    <= wr_data;
                default:            ;
            endcase
        end
    end

    // configuration fields; the user must write them only while the pipe is empty, unchecked by the block
    logic [7:0]  divisor;
    logic [15:0] inv_fx;
    logic [15:0] inv_fy;
    logic [15:0] cx;
    logic [15:0] cy;

    // a zero step behaves as one
    assign divisor = (step_reg == 8'd0) ? 8'd1 : step_reg;
    assign inv_fx  = intr_reg[63:48];
    assign inv_fy  = intr_reg[47:32];
    assign cx      = 16'(intr_reg[16 +: CBITS]);
    assign cy      = 16'(intr_reg[0 +: CBITS]);

    // ------------------------------------------------------------------
    // stage enables: a stage loads when empty or when its successor moves
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic s4_valid_reg, s5_valid_reg, s6_valid_reg;
    logic out_valid_reg;
    logic en1, en2, en3, en4, en5, en6, en_out;

    assign en_out = !out_valid_reg || point.ready;
    assign en6    = !s6_valid_reg  || en_out;
    assign en5    = !s5_valid_reg  || en6;
    assign en4    = !s4_valid_reg  || en5;
    assign en3    = !s3_valid_reg  || en4;
    assign en2    = !s2_valid_reg  || en3;
    assign en1    = !s1_valid_reg  || en2;

    assign pixel.ready = en1;

    // ------------------------------------------------------------------
    // stage 1: gates, offsets from the principal point, top remainder bits
    // ------------------------------------------------------------------
    logic signed [16:0] s1_du_reg, s1_dv_reg;
    logic [15:0]        s1_z_reg;
    logic               s1_gate_reg;
    logic [7:0]         s1_remu_reg, s1_remv_reg;
    logic [7:0]         s1_ulo_reg, s1_vlo_reg;
    side_t              s1_side_reg;

    logic  depth_ok;
    logic  conf_ok;
    side_t side_in;

    assign depth_ok = (pixel.depth_mm != 16'd0) && (pixel.depth_mm >= min_depth_reg)
                   && (pixel.depth_mm <= max_depth_reg);
    assign conf_ok  = pixel.confidence >= conf_min_reg;

    always_comb
    begin
        side_in.blue  = pixel.blue;
        side_in.green = pixel.green;
        side_in.red   = pixel.red;
        // absent labels read as all ones
        side_in.label = pixel.label_present ? pixel.label_in : 32'hFFFF_FFFF;
    end

    always_ff @(posedge clk)
    begin
        if (en1 && pixel.valid)
        begin
            s1_du_reg   <= signed'({1'b0, pixel.column, 4'b0000}) - signed'({1'b0, cx});
            s1_dv_reg   <= signed'({1'b0, pixel.row_index, 4'b0000}) - signed'({1'b0, cy});
            s1_z_reg    <= pixel.depth_mm;
            s1_gate_reg <= depth_ok && conf_ok;
            s1_remu_reg <= rem_step4(8'd0, pixel.column[11:8], divisor);
            s1_remv_reg <= rem_step4(8'd0, pixel.row_index[11:8], divisor);
            s1_ulo_reg  <= pixel.column[7:0];
            s1_vlo_reg  <= pixel.row_index[7:0];
            s1_side_reg <= side_in;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: offset times depth, middle remainder bits
    // ------------------------------------------------------------------
    logic signed [33:0] s2_duz_reg, s2_dvz_reg;
    logic [15:0]        s2_z_reg;
    logic               s2_gate_reg;
    logic [7:0]         s2_remu_reg, s2_remv_reg;
    logic [3:0]         s2_ulo_reg, s2_vlo_reg;
    side_t              s2_side_reg;

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            s2_duz_reg  <= s1_du_reg * signed'({1'b0, s1_z_reg});
            s2_dvz_reg  <= s1_dv_reg * signed'({1'b0, s1_z_reg});
            s2_z_reg    <= s1_z_reg;
            s2_gate_reg <= s1_gate_reg;
            s2_remu_reg <= rem_step4(s1_remu_reg, s1_ulo_reg[7:4], divisor);
            s2_remv_reg <= rem_step4(s1_remv_reg, s1_vlo_reg[7:4], divisor);
            s2_ulo_reg  <= s1_ulo_reg[3:0];
            s2_vlo_reg  <= s1_vlo_reg[3:0];
            s2_side_reg <= s1_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: scale by reciprocal focal length, last remainder bits
    // ------------------------------------------------------------------
    logic signed [50:0] s3_px_reg, s3_py_reg;
    logic [15:0]        s3_z_reg;
    logic               s3_keep_reg;
    side_t              s3_side_reg;

    logic [7:0] remu_final, remv_final;

    assign remu_final = rem_step4(s2_remu_reg, s2_ulo_reg, divisor);
    assign remv_final = rem_step4(s2_remv_reg, s2_vlo_reg, divisor);

    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            s3_px_reg   <= s2_duz_reg * signed'({1'b0, inv_fx});
            s3_py_reg   <= s2_dvz_reg * signed'({1'b0, inv_fy});
            s3_z_reg    <= s2_z_reg;
            s3_keep_reg <= s2_gate_reg && (remu_final == 8'd0) && (remv_final == 8'd0);
            s3_side_reg <= s2_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: round camera x/y to q.8 millimetres, form camera z
    // ------------------------------------------------------------------
    logic signed [34:0] s4_p_reg [3];
    logic               s4_keep_reg;
    side_t              s4_side_reg;

    logic signed [50:0] px_round, py_round;

    // half up, then floor
    assign px_round = s3_px_reg + 51'sd32768;
    assign py_round = s3_py_reg + 51'sd32768;

    always_ff @(posedge clk)
    begin
        if (en4 && s3_valid_reg)
        begin
            s4_p_reg[0] <= signed'(px_round[50:16]);
            s4_p_reg[1] <= signed'(py_round[50:16]);
            s4_p_reg[2] <= signed'(35'({s3_z_reg, 8'h00}));
            s4_keep_reg <= s3_keep_reg;
            s4_side_reg <= s3_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: nine rotation products
    // ------------------------------------------------------------------
    logic signed [50:0] s5_prod_reg [3][3];
    logic               s5_keep_reg;
    side_t              s5_side_reg;

    always_ff @(posedge clk)
    begin
        if (en5 && s4_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s5_prod_reg[i][0] <= signed'(row_reg[i][63:48]) * s4_p_reg[0];
                s5_prod_reg[i][1] <= signed'(row_reg[i][47:32]) * s4_p_reg[1];
                s5_prod_reg[i][2] <= signed'(row_reg[i][31:16]) * s4_p_reg[2];
            end
            s5_keep_reg <= s4_keep_reg;
            s5_side_reg <= s4_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: row sums with the rounding offset for the q2.14 x q.8 scale
    // ------------------------------------------------------------------
    logic signed [52:0] s6_acc_reg [3];
    logic               s6_keep_reg;
    side_t              s6_side_reg;

    always_ff @(posedge clk)
    begin
        if (en6 && s5_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s6_acc_reg[i] <= s5_prod_reg[i][0] + s5_prod_reg[i][1]
                               + s5_prod_reg[i][2] + 53'sd2097152;
            end
            s6_keep_reg <= s5_keep_reg;
            s6_side_reg <= s5_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // output register: drop to millimetres, add translation, saturate
    // ------------------------------------------------------------------
    logic signed [31:0] world_sum  [3];
    logic signed [20:0] world_next [3];
    logic signed [20:0] world_reg  [3];
    side_t              out_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            world_sum[i]  = signed'({s6_acc_reg[i][52], s6_acc_reg[i][52:22]})
                          + signed'({{16{row_reg[i][15]}}, row_reg[i][15:0]});
            world_next[i] = sat21(world_sum[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out && s6_valid_reg)
        begin
            for (int i = 0; i < 3; i++)
            begin
                world_reg[i] <= world_next[i];
            end
            out_side_reg <= s6_side_reg;
        end
    end

    // valid bits; a rejected pixel stops at the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= pixel.valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
            if (en6)
            begin
                s6_valid_reg <= s5_valid_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= s6_valid_reg && s6_keep_reg;
            end
        end
    end

    // point channel
    assign point.valid     = out_valid_reg;
    assign point.world_x   = world_reg[0];
    assign point.world_y   = world_reg[1];
    assign point.world_z   = world_reg[2];
    assign point.out_blue  = out_side_reg.blue;
    assign point.out_green = out_side_reg.green;
    assign point.out_red   = out_side_reg.red;
    assign point.label_out = out_side_reg.label;

endmodule

`default_nettype wire
